/* rtl/core/assert_macros.svh */
// Assertion helpers used by the list module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define OLIRF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the following cycle.
`define OLIRF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/olirf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package olirf_pkg;

  // Wide enough for any count or index up to the largest supported capacity.
  localparam int unsigned CNT_W = 9;

  typedef enum logic [2:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_REMOVE = 3'd2,
    OP_FIND   = 3'd3,
    OP_CLEAR  = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_APPEND,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_COMPARE,
    CELL_SCAN
  } cell_op_e;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] element;
    logic [7:0]         position;
  } in_item_t;

  typedef struct packed {
    logic       success;
    logic [3:0] found_index;
    logic [4:0] entry_count;
  } out_item_t;

  // Broadcast command from the controller to every cell.
  typedef struct packed {
    cell_op_e         op;
    logic [31:0]      element;
    logic [CNT_W-1:0] pos;
    logic [CNT_W-1:0] count;
  } cell_cmd_t;

endpackage

`default_nettype wire

/* rtl/core/olirf_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module olirf_cell
  import olirf_pkg::*;
#(
  parameter int unsigned IDX = 0
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cell_cmd_t   cmd_i,
  input  wire logic [31:0] left_entry_i,
  input  wire logic [31:0] right_entry_i,
  input  wire logic        right_match_i,
  output logic [31:0]      entry_o,
  output logic             match_o
);

  localparam logic [CNT_W-1:0] MyIdx = CNT_W'(IDX);

  logic [31:0] entry_d, entry_q;
  logic        match_d, match_q;

  // Pick the next entry from own value, neighbors or the new element, and the next match flag.
  always_comb begin
    entry_d = entry_q;
    match_d = match_q;
    case (cmd_i.op)
      CELL_APPEND: begin
        if (MyIdx == cmd_i.count) entry_d = cmd_i.element;
      end
      CELL_INSERT: begin
        if (MyIdx == cmd_i.pos) begin
          entry_d = cmd_i.element;
        end else if (MyIdx > cmd_i.pos) begin
          entry_d = left_entry_i;
        end
      end
      CELL_REMOVE: begin
        if (MyIdx >= cmd_i.pos) entry_d = right_entry_i;
      end
      CELL_COMPARE: begin
        match_d = (MyIdx < cmd_i.count) && (entry_q == cmd_i.element);
      end
      CELL_SCAN: begin
        match_d = right_match_i;
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  // Hold list storage; no reset needed.
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  // Hold match flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      match_q <= match_d;
    end
  end

  assign entry_o = entry_q;
  assign match_o = match_q;

endmodule

`default_nettype wire

/* rtl/core/ordered_list_insert_remove_find.sv */
// Append, insert, remove, clear and unused codes: the result is loaded at the accepting edge,
// and a new item is taken every cycle while the output drains.
// Find: a compare step loads the match flags, then they shift one cell per cycle toward cell 0
// until a hit reaches cell 0 or the scan reaches the last entry.
// A result held by a stalled output blocks the input until its transfer.
// Reset (async, active low) empties the list and drops any pending result.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ordered_list_insert_remove_find
  import olirf_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_data_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CapW = CW'(CAPACITY);

  state_e          state_d, state_q;
  logic [CW-1:0]   count_d, count_q;
  logic [CW-1:0]   scan_idx_d, scan_idx_q;
  logic            out_valid_d, out_valid_q;
  out_item_t       out_d, out_q;
  cell_cmd_t       cmd;
  logic            in_xfer, out_free, load_out;
  logic            full, hit, miss;
  logic            scan_busy, clear_xfer;
  logic [CNT_W-1:0] pos_w, cnt_w, pos_clamp;
  logic [31:0]     entry [CAPACITY];
  logic            match [CAPACITY];

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign scan_busy  = (state_q == ST_SCAN);
  assign clear_xfer = in_xfer && (op_e'(in_data_i.opcode) == OP_CLEAR);

  assign full      = (count_q == CapW);
  assign pos_w     = CNT_W'(in_data_i.position);
  assign cnt_w     = CNT_W'(count_q);
  assign pos_clamp = (pos_w > cnt_w) ? cnt_w : pos_w;
  assign hit       = match[0];
  assign miss      = ({1'b0, scan_idx_q} + 1'b1) >= {1'b0, count_q};

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer && (op_e'(in_data_i.opcode) == OP_FIND)) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if ((hit || miss) && out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Drive cell commands, count and result.
  always_comb begin
    cmd         = '{op: CELL_HOLD, element: in_data_i.element, pos: pos_clamp,
                    count: cnt_w};
    count_d     = count_q;
    scan_idx_d  = scan_idx_q;
    load_out    = 1'b0;
    out_d       = out_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          load_out          = 1'b1;
          out_d.success     = 1'b0;
          out_d.found_index = '0;
          case (op_e'(in_data_i.opcode))
            OP_APPEND: begin
              if (!full) begin
                cmd.op        = CELL_APPEND;
                count_d       = count_q + 1'b1;
                out_d.success = 1'b1;
              end
            end
            OP_INSERT: begin
              if (!full) begin
                cmd.op        = CELL_INSERT;
                count_d       = count_q + 1'b1;
                out_d.success = 1'b1;
              end
            end
            OP_REMOVE: begin
              if (pos_w < cnt_w) begin
                cmd.op        = CELL_REMOVE;
                count_d       = count_q - 1'b1;
                out_d.success = 1'b1;
              end
            end
            OP_FIND: begin
              cmd.op     = CELL_COMPARE;
              scan_idx_d = '0;
              load_out   = 1'b0;
            end
            OP_CLEAR: begin
              count_d       = '0;
              out_d.success = 1'b1;
            end
            default: begin
              out_d.success = 1'b0;
            end
          endcase
          out_d.entry_count = 5'(count_d);
        end
      end
      ST_SCAN: begin
        if (hit || miss) begin
          if (out_free) begin
            load_out          = 1'b1;
            out_d.success     = hit;
            out_d.found_index = hit ? 4'(scan_idx_q) : 4'd0;
            out_d.entry_count = 5'(count_q);
          end
        end else begin
          cmd.op     = CELL_SCAN;
          scan_idx_d = scan_idx_q + 1'b1;
        end
      end
      default: begin
        cmd.op = CELL_HOLD;
      end
    endcase
  end

  assign out_valid_d = load_out ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  // Advance control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      scan_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      scan_idx_q  <= scan_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold result payload until the output transfer.
  always_ff @(posedge clk_i) begin
    if (load_out) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Build the chain of cells; besides the broadcast command, each reads its neighbors only.
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [31:0] left_entry, right_entry;
    logic        right_match;
    if (k == 0) begin : g_first
      assign left_entry = cmd.element;
    end else begin : g_mid_l
      assign left_entry = entry[k-1];
    end
    if (k == CAPACITY - 1) begin : g_last
      assign right_entry = entry[k];
      assign right_match = 1'b0;
    end else begin : g_mid_r
      assign right_entry = entry[k+1];
      assign right_match = match[k+1];
    end
    olirf_cell #(
      .IDX (k)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .cmd_i         (cmd),
      .left_entry_i  (left_entry),
      .right_entry_i (right_entry),
      .right_match_i (right_match),
      .entry_o       (entry[k]),
      .match_o       (match[k])
    );
  end

  `OLIRF_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CapW, "count exceeds capacity")
  `OLIRF_ASSERT(a_scan_blocks, clk_i, rst_ni, !scan_busy || !in_ready_o, "input taken during scan")
  `OLIRF_ASSERT_NEXT(a_clear_empties, clk_i, rst_ni, clear_xfer, count_q == '0, "not cleared")
  `OLIRF_ASSERT_NEXT(a_scan_count_stable, clk_i, rst_ni, scan_busy, $stable(count_q), "count moved")

endmodule

`default_nettype wire
